>>> rtl/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
// Used by ptb_cell and periodic_timer_bank_top; depends on nothing else.
package ptb_pkg;

    localparam int TIME_W       = 48;
    localparam int IN_PERIOD_W  = 32;
    localparam int SLOT_FIELD_W = 3;
    localparam int STATUS_W     = 3;
    localparam int WAIT_W       = 32;
    localparam int CMD_W        = 2;

    localparam int DEF_N_SLOTS     = 8;
    localparam int DEF_PERIOD_BITS = 32;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_PERIOD = 3'd4;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              start;  // load elapsed time, clear remainder
        logic              step;   // one restoring division step
        logic [TIME_W-1:0] now;
    } t_cell_ctl;

endpackage

>>> rtl/periodic_timer_bank_top.sv
// Periodic timer bank: add, remove and next-expiry query over N_SLOTS slots.
// Add, remove, unused commands and a query of an empty bank: result registered in the cycle after accept.
// Query with valid timers: the result waits for the 48-step per-slot modulo and then the
// minimum chain through the cells; one item at a time.
// Reset (synchronous, active low) clears all valid marks and the handshake state.
// Depends on ptb_pkg and ptb_cell.
module periodic_timer_bank_top
    import ptb_pkg::*;
#(
    parameter int N_SLOTS     = DEF_N_SLOTS,
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, low bit up: command[1:0], period_us[33:2], slot_id[36:34],
    // now_us[84:37], zero fill [87:85].
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, low bit up: status[2:0], assigned_slot[5:3], wait_us[37:6],
    // zero fill [39:38].
    output logic [39:0] m_tdata
);

    localparam int SW    = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIME_W + N_SLOTS + 2);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(TIME_W - 1);
    localparam logic [CNT_W-1:0] CHAIN_LAST = CNT_W'(N_SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_CHAIN = 2'd2;

    // Input fields.
    logic [CMD_W-1:0]        in_cmd;
    logic [IN_PERIOD_W-1:0]  in_period;
    logic [SLOT_FIELD_W-1:0] in_slot;
    logic [TIME_W-1:0]       in_now;
    logic [PERIOD_BITS-1:0]  per_m;

    assign in_cmd    = s_tdata[1:0];
    assign in_period = s_tdata[33:2];
    assign in_slot   = s_tdata[36:34];
    assign in_now    = s_tdata[84:37];
    // Only the low PERIOD_BITS of the period are kept.
    assign per_m     = PERIOD_BITS'(in_period);

    logic [1:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [SW-1:0]       r_slot;
    logic [WAIT_W-1:0]   r_wait;

    logic                   accept;
    logic [N_SLOTS-1:0]     valid_vec;
    logic [N_SLOTS-1:0]     wr_vec;
    logic [N_SLOTS-1:0]     clr_vec;
    logic                   any_free;
    logic [SW-1:0]          free_idx;
    logic [SW-1:0]          sid_idx;
    logic                   sid_ok;
    t_cell_ctl              ctl;

    logic                   chain_any  [N_SLOTS+1];
    logic [PERIOD_BITS-1:0] chain_best [N_SLOTS+1];

    assign s_tready = (r_state == S_IDLE) && (!r_out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Lowest free slot.
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = N_SLOTS - 1; i >= 0; i--) begin
            if (!valid_vec[i]) begin
                any_free = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign sid_idx = SW'(in_slot);
    assign sid_ok  = (32'(in_slot) < 32'(N_SLOTS)) && valid_vec[sid_idx];

    always_comb begin
        wr_vec  = '0;
        clr_vec = '0;
        if (accept && in_cmd == CMD_ADD && per_m != '0 && any_free) begin
            wr_vec[free_idx] = 1'b1;
        end
        if (accept && in_cmd == CMD_REMOVE && sid_ok) begin
            clr_vec[sid_idx] = 1'b1;
        end
    end

    assign ctl.start = accept && (in_cmd == CMD_QUERY);
    assign ctl.step  = (r_state == S_DIV);
    assign ctl.now   = in_now;

    assign chain_any[0]  = 1'b0;
    assign chain_best[0] = '0;

    // Each cell reduces its own remainder and hands the running minimum on.
    for (genvar g = 0; g < N_SLOTS; g++) begin : g_cell
        ptb_cell #(
            .PERIOD_BITS(PERIOD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wr    (wr_vec[g]),
            .i_clr   (clr_vec[g]),
            .i_period(per_m),
            .i_any   (chain_any[g]),
            .i_best  (chain_best[g]),
            .o_valid (valid_vec[g]),
            .o_any   (chain_any[g+1]),
            .o_best  (chain_best[g+1])
        );
    end

    // Sequencer: division steps, then wait for the minimum to reach the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (ctl.start && valid_vec != '0) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_CHAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHAIN: begin
                    if (r_cnt == CHAIN_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && !(in_cmd == CMD_QUERY && valid_vec != '0)) begin
            r_out_valid <= 1'b1;
        end else if (r_state == S_CHAIN && r_cnt == CHAIN_LAST) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= ST_OK;
            r_slot   <= '0;
            r_wait   <= '0;
            case (in_cmd)
                CMD_ADD: begin
                    if (per_m == '0) begin
                        r_status <= ST_ZERO_PERIOD;
                    end else if (!any_free) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_slot <= free_idx;
                    end
                end
                CMD_REMOVE: begin
                    if (!sid_ok) begin
                        r_status <= ST_NOT_FOUND;
                    end
                end
                CMD_QUERY: begin
                    if (valid_vec == '0) begin
                        r_status <= ST_EMPTY;
                    end
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end else if (r_state == S_CHAIN && r_cnt == CHAIN_LAST) begin
            r_wait <= WAIT_W'(chain_best[N_SLOTS]);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_wait, SLOT_FIELD_W'(r_slot), r_status};

    // The block takes no item while a query is in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_tready)
        else $error("item accepted during a query");

    // While dividing, a shown result carries one of the defined status codes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !(r_out_valid && r_status != ST_OK && r_status != ST_FULL
            && r_status != ST_NOT_FOUND && r_status != ST_ZERO_PERIOD && r_status != ST_EMPTY))
        else $error("bad status while dividing");

    // An empty-bank result means no slot is valid.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_EMPTY) |-> (valid_vec == '0))
        else $error("empty status with valid timers");

    // A successful query finishes with at least one valid cell seen by the chain.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHAIN && r_cnt == CHAIN_LAST) |-> chain_any[N_SLOTS])
        else $error("minimum chain saw no valid timer");

endmodule

>>> rtl/ptb_cell.sv
// One timer slot: valid bit, period, start time, a bit-serial modulo unit
// and one stage of the running-minimum chain. Depends on ptb_pkg.
module ptb_cell
    import ptb_pkg::*;
#(
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic                   i_wr,
    input  logic                   i_clr,
    input  logic [PERIOD_BITS-1:0] i_period,
    input  logic                   i_any,
    input  logic [PERIOD_BITS-1:0] i_best,
    output logic                   o_valid,
    output logic                   o_any,
    output logic [PERIOD_BITS-1:0] o_best
);

    logic                   r_valid;
    logic [PERIOD_BITS-1:0] r_period;
    logic [TIME_W-1:0]      r_start;
    logic [TIME_W-1:0]      r_dvd;
    logic [PERIOD_BITS-1:0] r_rem;
    logic                   r_any;
    logic [PERIOD_BITS-1:0] r_best;

    logic [PERIOD_BITS:0]   shifted;
    logic [PERIOD_BITS-1:0] n_rem;
    logic [PERIOD_BITS-1:0] wait_val;
    logic                   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
        end else if (i_clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_period <= i_period;
            r_start  <= i_ctl.now;
        end
    end

    // Restoring remainder: one dividend bit enters per step, MSB first.
    // The remainder stays below the period, so it always fits PERIOD_BITS.
    always_comb begin
        shifted = {r_rem, r_dvd[TIME_W-1]};
        if (shifted >= {1'b0, r_period}) begin
            n_rem = PERIOD_BITS'(shifted - {1'b0, r_period});
        end else begin
            n_rem = shifted[PERIOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd <= i_ctl.now - r_start;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign wait_val = r_period - r_rem;
    assign take     = r_valid && (!i_any || (wait_val < i_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else begin
            r_any <= i_any || r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= take ? wait_val : i_best;
    end

    assign o_valid = r_valid;
    assign o_any   = r_any;
    assign o_best  = r_best;

endmodule
